// ===== design/klr_pkg.sv =====
// Shared types, constants and the boot notice table for the kernel log line rewriter.
package klr_pkg;

    // Character codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // Notice length and the header sequence positions that follow it
    localparam int NOTICE_LEN = 23;
    localparam int SEQ_W      = 5;
    localparam logic [SEQ_W-1:0] SEQ_NOTICE_END = SEQ_W'(NOTICE_LEN - 1);
    localparam logic [SEQ_W-1:0] SEQ_LT         = SEQ_W'(NOTICE_LEN);
    localparam logic [SEQ_W-1:0] SEQ_PRIO       = SEQ_W'(NOTICE_LEN + 1);
    localparam logic [SEQ_W-1:0] SEQ_GT         = SEQ_W'(NOTICE_LEN + 2);

    // Command queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_EXP_LT,
        PH_EXP_DIGIT,
        PH_EXP_GT,
        PH_EXP_LBRK,
        PH_STAMP,
        PH_EXP_SPACE,
        PH_TEXT,
        PH_DISCARD
    } phase_t;

    typedef enum logic {
        CMD_BYTE,
        CMD_HEAD
    } cmd_kind_t;

    // One work command from the parser to the emitter
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;    // text byte, or priority digit for a header
        logic       last;    // text byte ends the message
        logic       notice;  // header is preceded by the boot notice
    } cmd_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    function automatic logic [7:0] notice_char(input logic [SEQ_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h3C; // <
            5'd1:    ch = 8'h31; // 1
            5'd2:    ch = 8'h3E; // >
            5'd3:    ch = 8'h20;
            5'd4:    ch = 8'h2D;
            5'd5:    ch = 8'h2D;
            5'd6:    ch = 8'h2D;
            5'd7:    ch = 8'h20;
            5'd8:    ch = 8'h53; // S
            5'd9:    ch = 8'h59; // Y
            5'd10:   ch = 8'h53; // S
            5'd11:   ch = 8'h54; // T
            5'd12:   ch = 8'h45; // E
            5'd13:   ch = 8'h4D; // M
            5'd14:   ch = 8'h20;
            5'd15:   ch = 8'h42; // B
            5'd16:   ch = 8'h4F; // O
            5'd17:   ch = 8'h4F; // O
            5'd18:   ch = 8'h54; // T
            5'd19:   ch = 8'h20;
            5'd20:   ch = 8'h2D;
            5'd21:   ch = 8'h2D;
            5'd22:   ch = 8'h2D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/klr_front.sv =====
// Line parser: checks the line form per byte and issues emit commands.
module klr_front
    import klr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       push,
    output cmd_t       push_cmd
);

    phase_t     phase_reg, phase_next;
    logic [7:0] prio_reg, prio_next;
    logic       checked_reg, checked_next;
    logic       zeros_reg, zeros_next;
    logic       cand_reg, cand_next;
    logic [7:0] held_reg, held_next;
    logic       heldv_reg, heldv_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_EXP_LT;
            prio_reg    <= 8'h00;
            checked_reg <= 1'b0;
            zeros_reg   <= 1'b0;
            cand_reg    <= 1'b0;
            held_reg    <= 8'h00;
            heldv_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            prio_reg    <= prio_next;
            checked_reg <= checked_next;
            zeros_reg   <= zeros_next;
            cand_reg    <= cand_next;
            held_reg    <= held_next;
            heldv_reg   <= heldv_next;
        end
    end

    // Per-byte parse step
    always_comb
    begin
        phase_next   = phase_reg;
        prio_next    = prio_reg;
        checked_next = checked_reg;
        zeros_next   = zeros_reg;
        cand_next    = cand_reg;
        held_next    = held_reg;
        heldv_next   = heldv_reg;
        push         = 1'b0;
        push_cmd     = '{kind: CMD_BYTE, data: held_reg, last: 1'b0, notice: 1'b0};

        if (accept)
        begin
            if (in_byte == CH_NL)
            begin
                // end of line: flush the held byte as the message end
                if (phase_reg == PH_TEXT && heldv_reg)
                begin
                    push          = 1'b1;
                    push_cmd.last = 1'b1;
                end
                heldv_next = 1'b0;
                held_next  = 8'h00;
                phase_next = PH_EXP_LT;
            end
            else
            begin
                case (phase_reg)
                    PH_EXP_LT:
                    begin
                        phase_next = (in_byte == CH_LT) ? PH_EXP_DIGIT : PH_DISCARD;
                    end
                    PH_EXP_DIGIT:
                    begin
                        if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
                        begin
                            prio_next  = in_byte;
                            phase_next = PH_EXP_GT;
                        end
                        else
                        begin
                            phase_next = PH_DISCARD;
                        end
                    end
                    PH_EXP_GT:
                    begin
                        phase_next = (in_byte == CH_GT) ? PH_EXP_LBRK : PH_DISCARD;
                    end
                    PH_EXP_LBRK:
                    begin
                        if (in_byte == CH_LBRK)
                        begin
                            zeros_next = 1'b1;
                            cand_next  = 1'b0;
                            phase_next = PH_STAMP;
                        end
                        else
                        begin
                            phase_next = PH_DISCARD;
                        end
                    end
                    PH_STAMP:
                    begin
                        if (in_byte == CH_NUL)
                        begin
                            phase_next = PH_DISCARD;
                        end
                        else
                        begin
                            // first non-zero stamp char decides boot candidacy
                            if (zeros_reg && in_byte != CH_ZERO)
                            begin
                                zeros_next = 1'b0;
                                cand_next  = (in_byte == CH_DOT) || (in_byte == CH_RBRK);
                            end
                            if (in_byte == CH_RBRK)
                            begin
                                phase_next = PH_EXP_SPACE;
                            end
                        end
                    end
                    PH_EXP_SPACE:
                    begin
                        if (in_byte != CH_SPACE)
                        begin
                            phase_next = PH_DISCARD;
                        end
                        else
                        begin
                            push            = 1'b1;
                            push_cmd.kind   = CMD_HEAD;
                            push_cmd.data   = prio_reg;
                            push_cmd.notice = !checked_reg && cand_reg;
                            checked_next    = 1'b1;
                            held_next       = CH_SPACE;
                            heldv_next      = 1'b1;
                            phase_next      = PH_TEXT;
                        end
                    end
                    PH_TEXT:
                    begin
                        push       = heldv_reg;
                        held_next  = in_byte;
                        heldv_next = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_DISCARD;
                    end
                endcase
            end
        end
    end

endmodule

// ===== design/klr_queue.sv =====
// Short command queue between the parser and the emitter.
module klr_queue
    import klr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t stat
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push, do_pop;

    assign stat.count = cnt_reg;
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

// ===== design/klr_back.sv =====
// Emitter: expands queued commands into output bytes behind an output register.
module klr_back
    import klr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_boot
);

    logic             ovalid_reg, ovalid_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             olast_reg, olast_next;
    logic             oboot_reg, oboot_next;
    logic             active_reg, active_next;
    logic [SEQ_W-1:0] idx_reg, idx_next;
    logic [SEQ_W-1:0] cur_idx;
    logic             adv, take;

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;
    assign out_boot  = oboot_reg;

    assign adv  = !ovalid_reg || out_ready;
    assign take = adv && head_valid;

    // Position within a header sequence; a fresh header skips the notice if unused
    assign cur_idx = active_reg ? idx_reg : (head.notice ? '0 : SEQ_LT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        oboot_reg <= oboot_next;
    end

    // Byte selection and command retirement
    always_comb
    begin
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        oboot_next  = oboot_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        pop         = 1'b0;

        if (adv)
        begin
            ovalid_next = head_valid;
        end

        if (take)
        begin
            if (head.kind == CMD_BYTE)
            begin
                obyte_next = head.data;
                olast_next = head.last;
                oboot_next = 1'b0;
                pop        = 1'b1;
            end
            else
            begin
                olast_next = (cur_idx == SEQ_NOTICE_END);
                oboot_next = (cur_idx < SEQ_LT);
                case (cur_idx)
                    SEQ_LT:   obyte_next = CH_LT;
                    SEQ_PRIO: obyte_next = head.data;
                    SEQ_GT:   obyte_next = CH_GT;
                    default:  obyte_next = notice_char(cur_idx);
                endcase
                if (cur_idx == SEQ_GT)
                begin
                    pop         = 1'b1;
                    active_next = 1'b0;
                end
                else
                begin
                    active_next = 1'b1;
                    idx_next    = cur_idx + 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/kernel_log_line_rewriter.sv =====
// Top level: kernel log line rewriter (parser, command queue, emitter).
// Path: parsed commands pass through the command queue, then the emitter's output register.
// Throughput: one input word per cycle unless the queue is full; one output word per cycle
//   while m_tready is high. Sending a boot notice header may fill the 4-entry queue and stall input.
// Reset: rst_n asynchronous, active low; clears parse state, queue pointers and output valid.
module kernel_log_line_rewriter
    import klr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] is_boot_notice
);

    logic    push, pop;
    cmd_t    push_cmd, head;
    q_stat_t q_stat;

    assign s_tready = !q_stat.full;

    klr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd)
    );

    klr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    klr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_boot   (m_tuser)
    );

    // Queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("command queue overfilled");

    // Last word of the boot notice is the trailing dash
    a_notice_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tlast |-> m_tdata == CH_DASH)
        else $error("boot notice ends on wrong byte");

    // The notice is sent as a gapless burst
    a_notice_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid)
        else $error("gap inside boot notice");

    // Nothing is pushed while the queue is full
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into full queue");

endmodule
